@@ hw/rtl/mm2_pkg.sv @@
// Shared types, constants and helpers for the streaming MurmurHash2 block.
// No dependencies; used by every module under hw/rtl.
`timescale 1ns / 1ps
`default_nettype none

package mm2_pkg;

	localparam int unsigned WORD_W     = 32;
	localparam int unsigned LOW_W      = 16;
	localparam int unsigned NBYTES_W   = 3;
	localparam int unsigned IN_TDATA_W = 72;   // 32 + 32 + 3 packed, padded to bytes
	localparam int unsigned OUT_TDATA_W = 48;  // 16 + 32

	localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
	localparam int unsigned MIX_SHIFT   = 24;
	localparam int unsigned FIN_SHIFT_A = 13;
	localparam int unsigned FIN_SHIFT_B = 15;

	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	localparam logic [NBYTES_W-1:0] NBYTES_FULL = 3'd4;
	localparam logic [NBYTES_W-1:0] NBYTES_NONE = 3'd0;

	// what the back end does with one request
	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,   // empty tail, hash passes through
		OP_BLOCK = 2'd1,   // full word mixed as a block
		OP_TAIL  = 2'd2    // 1..3 tail bytes xored in, then multiplied
	} op_kind_t;

	// one queued request, front to back
	typedef struct packed {
		op_kind_t          kind;
		logic              first;    // start from init instead of running hash
		logic              last;     // finish the key, give a result
		logic [WORD_W-1:0] init;     // seed ^ key_length
		logic [WORD_W-1:0] operand;  // premixed word or masked tail
	} mm2_req_t;

	function automatic logic [WORD_W-1:0] tail_mask(input logic [NBYTES_W-1:0] nbytes);
		logic [WORD_W-1:0] m;
		case (nbytes)
			3'd1:    m = 32'h0000_00ff;
			3'd2:    m = 32'h0000_ffff;
			3'd3:    m = 32'h00ff_ffff;
			default: m = 32'h0000_0000;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mm2_front.sv @@
// Front end: accepts key words, classifies them and premixes full words (k = w*M, k^=k>>24, k*=M).
// Depends on mm2_pkg; feeds mm2_queue.
`timescale 1ns / 1ps
`default_nettype none

module mm2_front #(
	parameter int unsigned QUEUE_DEPTH = mm2_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                                      clk,
	input  wire                                      arst_n,
	input  wire  [mm2_pkg::WORD_W-1:0]               seed,
	input  wire                                      in_valid,
	output logic                                     in_ready,
	input  wire  [mm2_pkg::WORD_W-1:0]               key_length,
	input  wire  [mm2_pkg::WORD_W-1:0]               data_word,
	input  wire  [mm2_pkg::NBYTES_W-1:0]             bytes_valid,
	input  wire                                      last,
	input  wire  [$clog2(QUEUE_DEPTH+1)-1:0]         q_count,
	output logic                                     push,
	output mm2_pkg::mm2_req_t                        push_req
);

	localparam int unsigned OCC_W = $clog2(QUEUE_DEPTH + 3);

	logic                        accept;
	logic [OCC_W-1:0]            occ;
	mm2_pkg::op_kind_t           kind_in;
	logic                        inside_q;

	logic                        valid_s1, valid_s2;
	mm2_pkg::op_kind_t           kind_s1;
	logic                        first_s1, last_s1;
	logic [mm2_pkg::WORD_W-1:0]  init_s1, word_s1, k1_s1;
	mm2_pkg::mm2_req_t           req_s2;
	logic [mm2_pkg::WORD_W-1:0]  k1_shr;

	// everything in flight counts against queue space, so the pipe never stalls
	assign occ      = OCC_W'(q_count) + OCC_W'(valid_s1) + OCC_W'(valid_s2);
	assign in_ready = (occ < OCC_W'(QUEUE_DEPTH));
	assign accept   = in_valid && in_ready;

	always_comb begin
		if (!last) begin
			kind_in = mm2_pkg::OP_BLOCK;
		end else if (bytes_valid >= mm2_pkg::NBYTES_FULL) begin
			kind_in = mm2_pkg::OP_BLOCK;
		end else if (bytes_valid == mm2_pkg::NBYTES_NONE) begin
			kind_in = mm2_pkg::OP_NONE;
		end else begin
			kind_in = mm2_pkg::OP_TAIL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				inside_q <= !last;
			end
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	// stage 1: classify, first multiply
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= kind_in;
			first_s1 <= !inside_q;
			last_s1  <= last;
			init_s1  <= seed ^ key_length;
			word_s1  <= data_word & mm2_pkg::tail_mask(bytes_valid);
			k1_s1    <= data_word * mm2_pkg::MIX_MUL;
		end
	end

	assign k1_shr = k1_s1 ^ (k1_s1 >> mm2_pkg::MIX_SHIFT);

	// stage 2: second multiply, build the request
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			req_s2.kind    <= kind_s1;
			req_s2.first   <= first_s1;
			req_s2.last    <= last_s1;
			req_s2.init    <= init_s1;
			req_s2.operand <= (kind_s1 == mm2_pkg::OP_BLOCK) ?
				k1_shr * mm2_pkg::MIX_MUL : word_s1;
		end
	end

	assign push     = valid_s2;
	assign push_req = req_s2;

endmodule

`default_nettype wire

@@ hw/rtl/mm2_queue.sv @@
// Short request queue between front and back end, registers only.
// Depends on mm2_pkg for the request type.
`timescale 1ns / 1ps
`default_nettype none

module mm2_queue #(
	parameter int unsigned QUEUE_DEPTH = mm2_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  push,
	input  mm2_pkg::mm2_req_t                    push_req,
	input  wire                                  pop,
	output logic                                 not_empty,
	output mm2_pkg::mm2_req_t                    head_req,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]     count
);

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	mm2_pkg::mm2_req_t  slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_req;
		end
	end

	assign not_empty = (count_q != '0);
	assign head_req  = slots_q[rd_ptr_q];
	assign count     = count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count above depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> (count_q < CNT_W'(QUEUE_DEPTH)))
		else $error("push into full queue");

endmodule

`default_nettype wire

@@ hw/rtl/mm2_back.sv @@
// Back end: running hash update (one multiply per word), final avalanche and result register.
// Depends on mm2_pkg; drains mm2_queue.
`timescale 1ns / 1ps
`default_nettype none

module mm2_back (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            not_empty,
	input  mm2_pkg::mm2_req_t              head_req,
	output logic                           pop,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic [mm2_pkg::WORD_W-1:0]     hash_full
);

	logic [mm2_pkg::WORD_W-1:0] running_q;
	logic [mm2_pkg::WORD_W-1:0] base, mul_a, prod, h;
	logic                       fin_v_s1;
	logic [mm2_pkg::WORD_W-1:0] fin_s1;
	logic [mm2_pkg::WORD_W-1:0] fin_prod;
	logic                       hash_v_q;
	logic [mm2_pkg::WORD_W-1:0] hash_q;
	logic                       out_load, fin_free;

	assign out_load = !hash_v_q || out_ready;
	assign fin_free = !fin_v_s1 || out_load;
	// words never wait on the result side, only a key's last request does
	assign pop      = not_empty && (!head_req.last || fin_free);

	assign base  = head_req.first ? head_req.init : running_q;
	assign mul_a = (head_req.kind == mm2_pkg::OP_TAIL) ? (base ^ head_req.operand) : base;
	assign prod  = mul_a * mm2_pkg::MIX_MUL;

	always_comb begin
		case (head_req.kind)
			mm2_pkg::OP_BLOCK: h = prod ^ head_req.operand;
			mm2_pkg::OP_TAIL:  h = prod;
			mm2_pkg::OP_NONE:  h = base;
			default:           h = base;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= '0;
			fin_v_s1  <= 1'b0;
			hash_v_q  <= 1'b0;
		end else begin
			if (pop) begin
				running_q <= head_req.last ? '0 : h;
			end
			if (pop && head_req.last) begin
				fin_v_s1 <= 1'b1;
			end else if (out_load) begin
				fin_v_s1 <= 1'b0;
			end
			if (out_load) begin
				hash_v_q <= fin_v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head_req.last) begin
			fin_s1 <= h ^ (h >> mm2_pkg::FIN_SHIFT_A);
		end
	end

	assign fin_prod = fin_s1 * mm2_pkg::MIX_MUL;

	always_ff @(posedge clk) begin
		if (out_load && fin_v_s1) begin
			hash_q <= fin_prod ^ (fin_prod >> mm2_pkg::FIN_SHIFT_B);
		end
	end

	assign out_valid = hash_v_q;
	assign hash_full = hash_q;

endmodule

`default_nettype wire

@@ hw/rtl/murmur2_hash_16.sv @@
// Top level of the streaming MurmurHash2 (32-bit) block with 16-bit bucket index.
// Depends on mm2_pkg, mm2_front, mm2_queue and mm2_back.
//
// Usage:
//  - Slave stream: one request per 32-bit key word. tdata carries key_length,
//    data_word and bytes_valid; tlast marks the key's final word. key_length is
//    sampled on the first word of a key, bytes_valid (0..4, larger saturates to 4)
//    on the last one only. An empty key is a single tlast request, bytes_valid 0.
//  - Master stream: one result per key, {hash_full, hash_low}.
//  - seed_we/seed_wdata write the seed; write only while the block is idle.
//    A new seed applies from the next key's first word.
// Timing:
//  - One request accepted per cycle while results are taken. The running-hash loop
//    holds one 32x32 multiply per word; the word premix sits in two front stages.
//  - m_axis_tvalid rises once the last word has passed the two front stages, the
//    queue slot, the hash update and the avalanche.
//  - A 4-entry queue decouples front and back. When the result is not taken,
//    the back end keeps folding words in and can still move one more key's last
//    word into the avalanche stage; it holds at the last word after that, and
//    s_axis_tready falls once queue plus front stages are full.
//  - Reset clears the seed, the pipe and the queue; the block starts idle.
`timescale 1ns / 1ps
`default_nettype none

module murmur2_hash_16 #(
	parameter int unsigned QUEUE_DEPTH = mm2_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// seed register
	input  wire                                 seed_we,
	input  wire  [mm2_pkg::WORD_W-1:0]          seed_wdata,
	// key words in
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	// [31:0] key_length, [63:32] data_word, [66:64] bytes_valid, [71:67] zero
	input  wire  [mm2_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	input  wire                                 s_axis_tlast,
	// hashes out
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	// [15:0] hash_low, [47:16] hash_full
	output logic [mm2_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [mm2_pkg::WORD_W-1:0]   seed_q;
	logic                         push, pop, not_empty;
	mm2_pkg::mm2_req_t            push_req, head_req;
	logic [CNT_W-1:0]             q_count;
	logic [mm2_pkg::WORD_W-1:0]   hash_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (seed_we) begin
			seed_q <= seed_wdata;
		end
	end

	mm2_front #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.seed        (seed_q),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.key_length  (s_axis_tdata[31:0]),
		.data_word   (s_axis_tdata[63:32]),
		.bytes_valid (s_axis_tdata[66:64]),
		.last        (s_axis_tlast),
		.q_count     (q_count),
		.push        (push),
		.push_req    (push_req)
	);

	mm2_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_req  (push_req),
		.pop       (pop),
		.not_empty (not_empty),
		.head_req  (head_req),
		.count     (q_count)
	);

	mm2_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head_req  (head_req),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.hash_full (hash_full)
	);

	assign m_axis_tdata = {hash_full, hash_full[mm2_pkg::LOW_W-1:0]};

endmodule

`default_nettype wire

@@ verif/murmur2_hash_16_tb.sv @@
// Self-checking testbench for murmur2_hash_16: streams keys word by word and
// checks every hash against a local MurmurHash2 predictor or a typed-in value.
// Depends on mm2_pkg and murmur2_hash_16 from hw/rtl.
`timescale 1ns / 1ps

module murmur2_hash_16_tb;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned SETTLE_TICKS = 10;    // idle ticks after the last hash is back
	localparam int unsigned PHASE_ITEMS  = 135;

	typedef struct packed {
		logic [15:0] low;
		logic [31:0] full;
	} hash_pair_t;

	// one directed request; exp_full is only used when typed is set
	typedef struct packed {
		logic [31:0] klen;
		logic [31:0] word;
		logic [2:0]  nb;
		logic        last;
		logic        typed;
		logic [31:0] exp_full;
	} word_row_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_EVERY_THIRD,
		RX_LONG_STALL
	} rx_mode_t;

	logic clk;
	logic arst_n;
	logic seed_we;
	logic [mm2_pkg::WORD_W-1:0] seed_wdata;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [mm2_pkg::IN_TDATA_W-1:0] s_axis_tdata;
	logic s_axis_tlast;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [mm2_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

	// predictor state
	logic [31:0] seed_shadow = '0;
	logic [31:0] key_hash    = '0;
	logic        mid_key     = 1'b0;

	hash_pair_t  pending_hashes [$];
	int unsigned fail_count  = 0;
	int unsigned items_sent  = 0;
	int unsigned burst_left  = 0;
	int unsigned cycle_count = 0;

	murmur2_hash_16 DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.seed_we       (seed_we),
		.seed_wdata    (seed_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ---------------- predictor ----------------

	function automatic logic [31:0] absorb_word(input logic [31:0] h, input logic [31:0] w);
		logic [31:0] k;
		k = w * mm2_pkg::MIX_MUL;
		k = k ^ (k >> mm2_pkg::MIX_SHIFT);
		k = k * mm2_pkg::MIX_MUL;
		h = h * mm2_pkg::MIX_MUL;
		return h ^ k;
	endfunction

	function automatic logic [31:0] final_scramble(input logic [31:0] h);
		h = h ^ (h >> mm2_pkg::FIN_SHIFT_A);
		h = h * mm2_pkg::MIX_MUL;
		return h ^ (h >> mm2_pkg::FIN_SHIFT_B);
	endfunction

	// Advances the key state by one accepted request; done is set on the key's
	// last word, together with the finished hash.
	function automatic void hash_accept(input logic [31:0] klen, input logic [31:0] word,
			input logic [2:0] nb, input logic last, output bit done, output logic [31:0] hash);
		logic [31:0] h;
		int unsigned n;
		h = mid_key ? key_hash : (seed_shadow ^ klen);
		done = 1'b0;
		hash = '0;
		if (!last) begin
			key_hash = absorb_word(h, word);
			mid_key  = 1'b1;
		end else begin
			n = (nb > 3'd4) ? 4 : int'(nb);   // oversized count acts as a full word
			if (n == 4)
				h = absorb_word(h, word);
			else if (n != 0) begin
				h = h ^ (word & ((32'h1 << (8 * n)) - 32'h1));
				h = h * mm2_pkg::MIX_MUL;
			end
			hash     = final_scramble(h);
			done     = 1'b1;
			key_hash = '0;
			mid_key  = 1'b0;
		end
	endfunction

	// ---------------- sender ----------------

	// Called at a falling edge; returns at the falling edge after acceptance
	// with tvalid still high, so a following request keeps the bus busy.
	task automatic push_word(input logic [31:0] klen, input logic [31:0] word,
			input logic [2:0] nb, input logic last, input logic typed, input logic [31:0] typed_full);
		bit done;
		logic [31:0] hash;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {5'b0, nb, word, klen};
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		hash_accept(klen, word, nb, last, done, hash);
		if (done) begin
			if (typed)
				hash = typed_full;
			pending_hashes.push_back('{low: hash[15:0], full: hash});
		end
		items_sent++;
		@(negedge clk);
	endtask

	// bursts of random length, random gaps between them
	task automatic next_slot();
		int unsigned gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				gap = $urandom_range(1, 8);
				s_axis_tvalid <= 1'b0;
				repeat (gap) begin
					s_axis_tdata <= {8'($urandom), $urandom, $urandom};
					s_axis_tlast <= 1'($urandom_range(0, 1));
					@(negedge clk);
				end
			end
			burst_left = $urandom_range(1, 32);
		end
		burst_left--;
	endtask

	// hold off until every hash is back, then let the pipe settle
	task automatic drain_pipe();
		s_axis_tvalid <= 1'b0;
		while (pending_hashes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_TICKS) @(negedge clk);
	endtask

	task automatic write_seed(input logic [31:0] value);
		drain_pipe();
		seed_we     <= 1'b1;
		seed_wdata  <= value;
		seed_shadow = value;
		@(negedge clk);
		seed_we     <= 1'b0;
		seed_wdata  <= $urandom;
	endtask

	function automatic logic [31:0] pick_word();
		int unsigned sel;
		sel = $urandom_range(0, 15);
		if (sel == 0)
			return 32'h0;
		if (sel == 1)
			return 32'hffff_ffff;
		return $urandom;
	endfunction

	// One whole key: body words then a last word. key_length is usually the
	// true byte count; sometimes a mismatch or an extreme. Body words and
	// non-first words carry junk in the fields the block ignores there.
	task automatic send_random_key();
		int unsigned body_words;
		int unsigned sel;
		logic [2:0]  tail_n;
		logic [31:0] klen;
		sel = $urandom_range(0, 99);
		if (sel < 70)
			body_words = $urandom_range(0, 4);
		else if (sel < 95)
			body_words = $urandom_range(5, 12);
		else
			body_words = $urandom_range(13, 40);
		tail_n = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
		klen = 32'(body_words * 4 + ((tail_n > 3'd4) ? 4 : int'(tail_n)));
		sel = $urandom_range(0, 19);
		if (sel == 0)
			klen = $urandom;
		else if (sel == 1)
			klen = 32'h0;
		else if (sel == 2)
			klen = 32'hffff_ffff;
		for (int unsigned i = 0; i < body_words; i++) begin
			next_slot();
			push_word((i == 0) ? klen : $urandom, pick_word(), 3'($urandom_range(0, 7)),
				1'b0, 1'b0, '0);
		end
		next_slot();
		push_word((body_words == 0) ? klen : $urandom, pick_word(), tail_n, 1'b1, 1'b0, '0);
	endtask

	// Directed requests, run with the reset seed of zero. Only the empty key
	// at length zero has its hash typed in: the avalanche of zero is zero.
	word_row_t directed_rows [19] = '{
		'{32'h0000_0000, 32'h0000_0000, 3'd0, 1'b1, 1'b1, 32'h0000_0000},
		'{32'hffff_ffff, 32'hffff_ffff, 3'd0, 1'b1, 1'b0, '0},  // empty key, junk word
		'{32'h0000_0004, 32'hffff_ffff, 3'd4, 1'b1, 1'b0, '0},
		'{32'h0000_0004, 32'h0000_0000, 3'd4, 1'b1, 1'b0, '0},
		'{32'h0000_0001, 32'hffff_ffab, 3'd1, 1'b1, 1'b0, '0},  // bytes past the tail masked
		'{32'h0000_0002, 32'hffff_1234, 3'd2, 1'b1, 1'b0, '0},
		'{32'h0000_0003, 32'hff00_ffff, 3'd3, 1'b1, 1'b0, '0},
		'{32'h0000_0004, 32'h1234_5678, 3'd5, 1'b1, 1'b0, '0},  // oversized counts
		'{32'h0000_0004, 32'h1234_5678, 3'd6, 1'b1, 1'b0, '0},
		'{32'h0000_0004, 32'h1234_5678, 3'd7, 1'b1, 1'b0, '0},
		'{32'h0000_0008, 32'hffff_ffff, 3'd7, 1'b0, 1'b0, '0},  // body: count ignored
		'{32'hdead_beef, 32'h0000_0000, 3'd4, 1'b1, 1'b0, '0},  // length ignored mid-key
		'{32'h0000_0064, 32'h6162_6364, 3'd2, 1'b1, 1'b0, '0},  // length mismatch
		'{32'h0000_000b, 32'h0302_0100, 3'd0, 1'b0, 1'b0, '0},
		'{32'hffff_ffff, 32'h0706_0504, 3'd5, 1'b0, 1'b0, '0},
		'{32'h0000_0000, 32'h000a_0908, 3'd3, 1'b1, 1'b0, '0},
		'{32'h0000_0004, 32'h89ab_cdef, 3'd0, 1'b0, 1'b0, '0},
		'{32'h0000_0004, 32'h0000_0000, 3'd0, 1'b1, 1'b0, '0},  // body word, empty tail
		'{32'h8000_0000, 32'h8000_0000, 3'd4, 1'b1, 1'b0, '0}
	};

	initial begin
		logic [31:0] seed_plan [6];
		int unsigned phase_goal;
		arst_n        = 1'b0;
		seed_we       = 1'b0;
		seed_wdata    = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		seed_plan = '{32'hffff_ffff, 32'h0000_0000, 32'h8000_0000, $urandom, $urandom,
			32'h0000_0001};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			next_slot();
			push_word(directed_rows[i].klen, directed_rows[i].word, directed_rows[i].nb,
				directed_rows[i].last, directed_rows[i].typed, directed_rows[i].exp_full);
		end

		// each phase ends on a whole key, so the seed write lands between keys
		foreach (seed_plan[p]) begin
			write_seed(seed_plan[p]);
			phase_goal = items_sent + PHASE_ITEMS;
			while (items_sent < phase_goal) begin
				send_random_key();
				if ($urandom_range(0, 39) == 0)
					drain_pipe();
			end
		end

		drain_pipe();
		if (fail_count == 0 && pending_hashes.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// ---------------- receiver ----------------

	initial begin
		rx_mode_t    mode;
		int unsigned stall_left;
		int unsigned tick;
		m_axis_tready = 1'b0;
		stall_left    = 0;
		tick          = 0;
		forever begin
			mode = rx_mode_t'($urandom_range(0, 3));
			repeat ($urandom_range(20, 80)) begin
				@(negedge clk);
				tick++;
				case (mode)
					RX_OPEN: begin
						m_axis_tready <= 1'b1;
					end
					RX_COIN: begin
						m_axis_tready <= 1'($urandom_range(0, 1));
					end
					RX_EVERY_THIRD: begin
						m_axis_tready <= (tick % 3 == 0);
					end
					default: begin
						if (stall_left == 0) begin
							m_axis_tready <= 1'b1;
							stall_left = $urandom_range(4, 24);
						end else begin
							m_axis_tready <= 1'b0;
							stall_left--;
						end
					end
				endcase
			end
		end
	end

	// ---------------- checker ----------------

	always @(posedge clk) begin
		hash_pair_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_hashes.size() == 0) begin
				$error("unexpected hash %h", m_axis_tdata);
				fail_count++;
			end else begin
				want = pending_hashes.pop_front();
				if (m_axis_tdata[15:0] !== want.low) begin
					$error("hash_low expected %h got %h", want.low, m_axis_tdata[15:0]);
					fail_count++;
				end
				if (m_axis_tdata[47:16] !== want.full) begin
					$error("hash_full expected %h got %h", want.full, m_axis_tdata[47:16]);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

endmodule
